>>> rtl/mkd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mkd_pkg;

  // field widths
  localparam int TICK_W         = 8;
  localparam int CHAR_INDEX_W   = 6;
  localparam int PATTERN_BITS_W = 8;
  localparam int PATTERN_LEN_W  = 4;
  localparam int CFG_INDEX_W    = 2;
  localparam int CFG_DATA_W     = 8;

  // default build and queue sizing
  localparam int MAX_SYMBOLS_DEFAULT = 8;
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_DOT_MAX   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DASH_MAX  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GAP_TICKS = 2'd2;

  // register reset values
  localparam logic [TICK_W-1:0] DOT_MAX_RESET   = 8'd1;
  localparam logic [TICK_W-1:0] DASH_MAX_RESET  = 8'd3;
  localparam logic [TICK_W-1:0] GAP_TICKS_RESET = 8'd15;

  localparam logic [TICK_W-1:0] TICK_SAT = '1;

  // key levels
  localparam logic KEY_PRESSED  = 1'b0;
  localparam logic KEY_RELEASED = 1'b1;

  // symbol encoding
  localparam logic SYM_DOT  = 1'b0;
  localparam logic SYM_DASH = 1'b1;

  // code table: letters A-Z then digits 0-9, bit i is symbol i, 1 dash
  localparam int NUM_CHARS    = 36;
  localparam int CODE_MAX_LEN = 5;
  localparam int CODE_LEN_W   = 3;

  localparam logic [CODE_LEN_W-1:0] CODE_LEN [NUM_CHARS] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4,
    3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1,
    3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
  };

  localparam logic [CODE_MAX_LEN-1:0] CODE_BITS [NUM_CHARS] = '{
    5'd2,  5'd1,  5'd5,  5'd1,  5'd0,  5'd4,  5'd3,  5'd0,  5'd0,  5'd14,
    5'd5,  5'd2,  5'd3,  5'd1,  5'd7,  5'd6,  5'd11, 5'd2,  5'd0,  5'd1,
    5'd4,  5'd8,  5'd6,  5'd9,  5'd13, 5'd3,
    5'd31, 5'd30, 5'd28, 5'd24, 5'd16, 5'd0,  5'd1,  5'd3,  5'd7,  5'd15
  };

  typedef struct packed {
    logic [TICK_W-1:0] dot_max;
    logic [TICK_W-1:0] dash_max;
    logic [TICK_W-1:0] gap_ticks;
  } cfg_t;

  typedef struct packed {
    logic                    hit;
    logic [CHAR_INDEX_W-1:0] index;
  } match_t;

  // first table entry whose length and symbols both match
  function automatic match_t match_code(input logic [CODE_MAX_LEN-1:0] bits,
                                        input logic [CODE_LEN_W-1:0] len);
    match_t m;
    m = '0;
    for (int k = NUM_CHARS - 1; k >= 0; k--) begin
      if (len == CODE_LEN[k] && bits == CODE_BITS[k]) begin
        m.hit   = 1'b1;
        m.index = CHAR_INDEX_W'(k);
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

>>> rtl/mkd_key_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mkd_key_if;
  logic valid;
  logic ready;
  logic key_level;

  modport source (output valid, output key_level, input ready);
  modport sink (input valid, input key_level, output ready);
endinterface

`default_nettype wire

>>> rtl/mkd_char_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mkd_char_if
  import mkd_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic [CHAR_INDEX_W-1:0]   char_index;
  logic                      known;
  logic [PATTERN_BITS_W-1:0] pattern_bits;
  logic [PATTERN_LEN_W-1:0]  pattern_length;
  logic                      overflow;

  modport source (output valid, output char_index, output known, output pattern_bits,
                  output pattern_length, output overflow, input ready);
  modport sink (input valid, input char_index, input known, input pattern_bits,
                input pattern_length, input overflow, output ready);
endinterface

`default_nettype wire

>>> rtl/mkd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module mkd_front
  import mkd_pkg::*;
#(
  parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEFAULT
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire cfg_t                                  cfg,
  input  wire logic                                  take,
  input  wire logic                                  key_level,
  output logic                                       push,
  output logic [MAX_SYMBOLS+$clog2(MAX_SYMBOLS+1):0] push_data
);

  localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
  localparam int IDX_W = $clog2(MAX_SYMBOLS);

  logic                   previous_level;
  logic [TICK_W-1:0]      press_ticks;
  logic [TICK_W-1:0]      release_ticks;
  logic                   char_started;
  logic [MAX_SYMBOLS-1:0] symbol_store;
  logic [CNT_W-1:0]       symbol_count;
  logic                   overflow_flag;

  logic [TICK_W-1:0]      press_ticks_next;
  logic [TICK_W-1:0]      release_ticks_next;
  logic                   char_started_next;
  logic [MAX_SYMBOLS-1:0] symbol_store_next;
  logic [CNT_W-1:0]       symbol_count_next;
  logic                   overflow_flag_next;
  logic                   append;
  logic                   append_sym;
  logic                   emit;

  always_comb begin
    press_ticks_next   = press_ticks;
    release_ticks_next = release_ticks;
    char_started_next  = char_started;
    symbol_store_next  = symbol_store;
    symbol_count_next  = symbol_count;
    overflow_flag_next = overflow_flag;
    append             = 1'b0;
    append_sym         = SYM_DOT;

    if (key_level == KEY_PRESSED) begin
      if (press_ticks != TICK_SAT) begin
        press_ticks_next = press_ticks + 1'b1;
      end
      release_ticks_next = '0;
    end else begin
      if (release_ticks != TICK_SAT) begin
        release_ticks_next = release_ticks + 1'b1;
      end
      // release edge classifies the press that just ended
      if (previous_level == KEY_PRESSED) begin
        char_started_next = 1'b1;
        if (press_ticks <= cfg.dot_max) begin
          append     = 1'b1;
          append_sym = SYM_DOT;
        end else if (press_ticks <= cfg.dash_max) begin
          append     = 1'b1;
          append_sym = SYM_DASH;
        end
      end
      press_ticks_next = '0;
    end

    if (append) begin
      if (symbol_count < CNT_W'(MAX_SYMBOLS)) begin
        symbol_store_next[symbol_count[IDX_W-1:0]] = append_sym;
        symbol_count_next = symbol_count + 1'b1;
      end else begin
        overflow_flag_next = 1'b1;
      end
    end

    emit = (release_ticks_next >= cfg.gap_ticks) && char_started_next;
  end

  assign push      = take && emit;
  assign push_data = {overflow_flag_next, symbol_count_next, symbol_store_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_level <= KEY_RELEASED;
      press_ticks    <= '0;
      release_ticks  <= '0;
      char_started   <= 1'b0;
      symbol_store   <= '0;
      symbol_count   <= '0;
      overflow_flag  <= 1'b0;
    end else if (take) begin
      previous_level <= key_level;
      press_ticks    <= press_ticks_next;
      if (emit) begin
        release_ticks <= '0;
        char_started  <= 1'b0;
        symbol_store  <= '0;
        symbol_count  <= '0;
        overflow_flag <= 1'b0;
      end else begin
        release_ticks <= release_ticks_next;
        char_started  <= char_started_next;
        symbol_store  <= symbol_store_next;
        symbol_count  <= symbol_count_next;
        overflow_flag <= overflow_flag_next;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/mkd_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module mkd_queue
  import mkd_pkg::*;
#(
  parameter int WIDTH = 1,
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      head,
  output logic                  empty
);

  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW  = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    fill;
  logic             do_push;
  logic             do_pop;

  assign empty   = (fill == '0);
  assign full    = (fill == CW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/mkd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module mkd_back
  import mkd_pkg::*;
#(
  parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEFAULT
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst,
  input  wire logic                                       empty,
  input  wire logic [MAX_SYMBOLS+$clog2(MAX_SYMBOLS+1):0] head,
  output logic                                            pop,
  mkd_char_if.source                                      result
);

  localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);

  logic [MAX_SYMBOLS-1:0] store;
  logic [CNT_W-1:0]       count;
  logic                   ovf;
  logic                   len_fits;
  match_t                 m;
  logic                   hit;

  assign store = head[MAX_SYMBOLS-1:0];
  assign count = head[MAX_SYMBOLS+CNT_W-1:MAX_SYMBOLS];
  assign ovf   = head[MAX_SYMBOLS+CNT_W];

  // patterns longer than any code never match
  assign len_fits = (count <= CNT_W'(CODE_MAX_LEN));
  assign m        = match_code(CODE_MAX_LEN'(store), CODE_LEN_W'(count));
  assign hit      = len_fits && !ovf && m.hit;

  assign pop = !empty && (!result.valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (pop) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result.char_index     <= hit ? m.index : '0;
      result.known          <= hit;
      result.pattern_bits   <= PATTERN_BITS_W'(store);
      result.pattern_length <= PATTERN_LEN_W'(count);
      result.overflow       <= ovf;
    end
  end

endmodule

`default_nettype wire

>>> rtl/morse_key_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none

// morse key decoder: takes one sampled key level per request on the key channel
// (0 pressed, 1 released) and, when a character ends, returns one request on the
// result channel with the decoded letter or digit index, a known flag, the raw
// dot/dash pattern, its length and an overflow flag. the block takes one key
// sample every clock while key ready is high; the per-sample counter update is
// a registered step in the front end. a finished character is written into the
// queue, then table matched into the output register when the result port is
// free. key ready drops only when the two-entry character queue is full behind a
// stalled result port. dot_max, dash_max and gap_ticks are written through
// cfg_we / cfg_index / cfg_data; write them while no character is in flight.
module morse_key_decoder_core
  import mkd_pkg::*;
#(
  parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  mkd_key_if.sink                     key,
  mkd_char_if.source                  result,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CNT_W   = $clog2(MAX_SYMBOLS + 1);
  // queue entry: overflow flag, symbol count, symbol store
  localparam int ENTRY_W = MAX_SYMBOLS + CNT_W + 1;

  cfg_t               cfg;
  logic               take;
  logic               push;
  logic [ENTRY_W-1:0] push_data;
  logic               q_full;
  logic               q_empty;
  logic               pop;
  logic [ENTRY_W-1:0] head;

  // configuration registers, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dot_max   <= DOT_MAX_RESET;
      cfg.dash_max  <= DASH_MAX_RESET;
      cfg.gap_ticks <= GAP_TICKS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DOT_MAX:   cfg.dot_max   <= cfg_data;
        REG_DASH_MAX:  cfg.dash_max  <= cfg_data;
        REG_GAP_TICKS: cfg.gap_ticks <= cfg_data;
        default:       cfg           <= cfg;
      endcase
    end
  end

  // a sample can always be taken while the queue has room for the character
  // it might close
  assign key.ready = !q_full;
  assign take      = key.valid && key.ready;

  // front end: press/release counting, symbol classification, gap detection
  mkd_front #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .take      (take),
    .key_level (key.key_level),
    .push      (push),
    .push_data (push_data)
  );

  // finished characters wait here so the front never sees output stalls directly
  mkd_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH_DEFAULT)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty)
  );

  // back end: table match and result register
  mkd_back #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .empty  (q_empty),
    .head   (head),
    .pop    (pop),
    .result (result)
  );

`ifndef NO_ASSERTIONS
  // unknown characters carry index zero
  a_unknown_index: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.known |-> result.char_index == '0)
    else $error("unknown character with nonzero index");

  // a matched character never has overflow and has one to five symbols
  a_known_shape: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.known |-> !result.overflow &&
      result.pattern_length != '0 && result.pattern_length <= PATTERN_LEN_W'(CODE_MAX_LEN))
    else $error("matched character with impossible pattern");

  // the front never closes a character while the queue is full
  a_no_lost_char: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("character pushed into full queue");
`endif

endmodule

`default_nettype wire
